FILE: sv/scr_pkg.sv
// Shared widths, codes, types and helper functions for the sphere collision response block.
// Used by every module of the block; it depends on nothing else.
`default_nettype none

package scr_pkg;

   // Field and lane widths.
   localparam int COORD_W = 16;
   localparam int VEC_W   = 48;
   localparam int AXES    = 3;
   localparam int AGENTS  = 2;
   localparam int LANES   = AGENTS * AXES;

   // Internal arithmetic widths.
   localparam int DIFF_W = 18;  // centre difference, signed
   localparam int SQ_W   = 36;  // one squared difference term, signed
   localparam int PRD_W  = 34;  // velocity times difference, signed
   localparam int DOT_W  = 36;  // dot product, signed
   localparam int DSQ_W  = 35;  // squared distance, unsigned
   localparam int RS_W   = 17;  // radius sum, unsigned
   localparam int RSQ_W  = 34;  // squared radius sum, unsigned
   localparam int EPS2_W = 32;  // squared epsilon, unsigned
   localparam int NPR_W  = 54;  // dot times difference, signed
   localparam int MAG_W  = 52;  // magnitude of that product
   localparam int NUM_W  = 54;  // rounding dividend
   localparam int DEN_W  = 36;  // rounding divisor
   localparam int QUO_W  = 17;  // quotient bits, one per divider stage
   localparam int PROJ_W = 18;  // signed projection
   localparam int SAT_W  = 26;  // wide value ahead of 16-bit saturation
   localparam int TSP_W  = 33;  // velocity times step, signed
   localparam int RND_W  = 24;  // rounded step magnitude

   // Pipeline depth from an accepted start to the result strobe.
   localparam int FRONT_STAGES = 5;
   localparam int BACK_STAGES  = 3;
   localparam int LATENCY      = FRONT_STAGES + QUO_W + BACK_STAGES;

   // Register file.
   localparam int CSR_IDX_W = 8;
   localparam logic [CSR_IDX_W-1:0] CSR_TIME_STEP   = 8'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_OVERLAP_EPS = 8'd1;
   localparam logic [COORD_W-1:0]   TIME_STEP_RESET = 16'd256;
   localparam logic [COORD_W-1:0]   OVERLAP_RESET   = 16'd1;

   // Contact status codes.
   localparam logic [1:0] STATUS_NONE    = 2'd0;
   localparam logic [1:0] STATUS_HIT     = 2'd1;
   localparam logic [1:0] STATUS_OVERLAP = 2'd2;

   // Pass-through vectors of one agent pair.
   typedef struct packed {
      logic [VEC_W-1:0] pos_first;
      logic [VEC_W-1:0] pos_second;
      logic [VEC_W-1:0] prev_first;
      logic [VEC_W-1:0] prev_second;
      logic [VEC_W-1:0] vel_first;
      logic [VEC_W-1:0] vel_second;
   } agents_type;

   // Control and pass-through data that travel alongside the arithmetic.
   typedef struct packed {
      logic       valid;
      logic [1:0] status;
      logic       fixed_first;
      logic       fixed_second;
      agents_type agents;
   } carry_type;

   // One signed Q8.8 coordinate out of a packed vector.
   function automatic logic signed [COORD_W-1:0] lane(input logic [VEC_W-1:0] vec,
                                                      input int k);
      return vec[COORD_W*k +: COORD_W];
   endfunction

   // Clamp to the signed 16-bit range.
   function automatic logic signed [COORD_W-1:0] sat16(input logic signed [SAT_W-1:0] v);
      logic signed [COORD_W-1:0] r;
      if (v > 32767) begin
         r = 16'sh7fff;
      end else if (v < -32768) begin
         r = -16'sh8000;
      end else begin
         r = v[COORD_W-1:0];
      end
      return r;
   endfunction

endpackage

`default_nettype wire

FILE: sv/scr_front.sv
// Front half of the pipeline: centre difference, distance and dot products,
// contact decision and the rounding dividend for each projection. Uses scr_pkg.
`default_nettype none

module scr_front (
   input  logic                                           clock,
   input  logic                                           reset,
   input  logic                                           in_valid,
   input  scr_pkg::agents_type                            in_agents,
   input  logic [scr_pkg::COORD_W-1:0]                    in_mass_first,
   input  logic [scr_pkg::COORD_W-1:0]                    in_mass_second,
   input  logic [scr_pkg::COORD_W-1:0]                    in_radius_first,
   input  logic [scr_pkg::COORD_W-1:0]                    in_radius_second,
   input  logic [scr_pkg::COORD_W-1:0]                    overlap_eps,
   output scr_pkg::carry_type                             out_carry,
   output logic [scr_pkg::LANES-1:0][scr_pkg::NUM_W-1:0]  out_num,
   output logic [scr_pkg::DEN_W-1:0]                      out_den,
   output logic [scr_pkg::LANES-1:0]                      out_neg
);
   import scr_pkg::*;

   // Stage 1: centre difference, radius sum and nonzero-velocity flags.
   logic                      v1_ff;
   agents_type                ag1_ff;
   logic signed [DIFF_W-1:0]  d1_ff [AXES];
   logic signed [DIFF_W-1:0]  d1_in [AXES];
   logic                      nzf1_ff, nzs1_ff;
   logic [RS_W-1:0]           rs1_ff;

   // Stage 2: products.
   logic                      v2_ff;
   agents_type                ag2_ff;
   logic signed [DIFF_W-1:0]  d2s_ff [AXES];
   logic signed [SQ_W-1:0]    sq2_ff [AXES];
   logic signed [PRD_W-1:0]   pf2_ff [AXES];
   logic signed [PRD_W-1:0]   ps2_ff [AXES];
   logic [RSQ_W-1:0]          rsq2_ff;
   logic [EPS2_W-1:0]         eps2_ff;
   logic                      nzf2_ff, nzs2_ff;

   // Stage 3: sums and contact decision.
   logic                      v3_ff;
   agents_type                ag3_ff;
   logic signed [DIFF_W-1:0]  d3_ff [AXES];
   logic [DSQ_W-1:0]          dsq3_ff, dsq3_in;
   logic signed [DOT_W-1:0]   dot3_ff [AGENTS];
   logic signed [DOT_W-1:0]   dot3_in [AGENTS];
   logic signed [SQ_W+1:0]    sqsum;
   logic [1:0]                st3_ff, st3_in;
   logic                      fxf3_ff, fxf3_in, fxs3_ff, fxs3_in;

   // Stage 4: dot product times each difference component.
   logic                      v4_ff;
   agents_type                ag4_ff;
   logic [DSQ_W-1:0]          dsq4_ff;
   logic signed [NPR_W-1:0]   pr4_ff [LANES];
   logic [1:0]                st4_ff;
   logic                      fxf4_ff, fxs4_ff;

   // Stage 5 combinational: magnitude and rounding dividend.
   logic signed [NPR_W-1:0]   absv [LANES];
   logic [MAG_W-1:0]          mag [LANES];

   // Stage 1 logic: the mass lifts each centre in y.
   always_comb begin
      for (int k = 0; k < AXES; k++) begin
         d1_in[k] = DIFF_W'(lane(in_agents.pos_second, k)) -
                    DIFF_W'(lane(in_agents.pos_first, k));
         if (k == 1) begin
            d1_in[k] = d1_in[k] + $signed({2'b00, in_mass_second}) -
                       $signed({2'b00, in_mass_first});
         end
      end
   end

   // Stage 3 logic: squared distance, dot products and decision.
   always_comb begin
      sqsum = (SQ_W+2)'(sq2_ff[0]) + (SQ_W+2)'(sq2_ff[1]) + (SQ_W+2)'(sq2_ff[2]);
      dsq3_in = sqsum[DSQ_W-1:0];
      dot3_in[0] = DOT_W'(pf2_ff[0]) + DOT_W'(pf2_ff[1]) + DOT_W'(pf2_ff[2]);
      dot3_in[1] = DOT_W'(ps2_ff[0]) + DOT_W'(ps2_ff[1]) + DOT_W'(ps2_ff[2]);
      if (dsq3_in < DSQ_W'(eps2_ff)) begin
         st3_in = STATUS_OVERLAP;
      end else if (dsq3_in < DSQ_W'(rsq2_ff)) begin
         st3_in = STATUS_HIT;
      end else begin
         st3_in = STATUS_NONE;
      end
      fxf3_in = (st3_in == STATUS_HIT) && (dsq3_in != '0) && nzf2_ff && (dot3_in[0] > 0);
      fxs3_in = (st3_in == STATUS_HIT) && (dsq3_in != '0) && nzs2_ff && (dot3_in[1] < 0);
   end

   // Stage 5 logic: split sign from magnitude.
   always_comb begin
      for (int i = 0; i < LANES; i++) begin
         absv[i] = pr4_ff[i][NPR_W-1] ? -pr4_ff[i] : pr4_ff[i];
         mag[i]  = absv[i][MAG_W-1:0];
      end
   end

   // Valid bits.
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
      end
   end

   // Data path registers; the output valid bit shares this block with its carry.
   always_ff @(posedge clock) begin
      if (reset) begin
         out_carry.valid <= 1'b0;
      end else begin
         out_carry.valid <= v4_ff;
      end
      // Stage 1.
      ag1_ff  <= in_agents;
      nzf1_ff <= |in_agents.vel_first;
      nzs1_ff <= |in_agents.vel_second;
      rs1_ff  <= {1'b0, in_radius_first} + {1'b0, in_radius_second};
      for (int k = 0; k < AXES; k++) begin
         d1_ff[k] <= d1_in[k];
      end
      // Stage 2.
      ag2_ff  <= ag1_ff;
      nzf2_ff <= nzf1_ff;
      nzs2_ff <= nzs1_ff;
      rsq2_ff <= RSQ_W'(rs1_ff) * RSQ_W'(rs1_ff);
      eps2_ff <= EPS2_W'(overlap_eps) * EPS2_W'(overlap_eps);
      for (int k = 0; k < AXES; k++) begin
         d2s_ff[k] <= d1_ff[k];
         sq2_ff[k] <= d1_ff[k] * d1_ff[k];
         pf2_ff[k] <= lane(ag1_ff.vel_first, k) * d1_ff[k];
         ps2_ff[k] <= lane(ag1_ff.vel_second, k) * d1_ff[k];
      end
      // Stage 3.
      ag3_ff  <= ag2_ff;
      dsq3_ff <= dsq3_in;
      st3_ff  <= st3_in;
      fxf3_ff <= fxf3_in;
      fxs3_ff <= fxs3_in;
      for (int k = 0; k < AXES; k++) begin
         d3_ff[k] <= d2s_ff[k];
      end
      for (int a = 0; a < AGENTS; a++) begin
         dot3_ff[a] <= dot3_in[a];
      end
      // Stage 4.
      ag4_ff  <= ag3_ff;
      dsq4_ff <= dsq3_ff;
      st4_ff  <= st3_ff;
      fxf4_ff <= fxf3_ff;
      fxs4_ff <= fxs3_ff;
      for (int a = 0; a < AGENTS; a++) begin
         for (int k = 0; k < AXES; k++) begin
            pr4_ff[a*AXES+k] <= dot3_ff[a] * d3_ff[k];
         end
      end
      // Stage 5: dividend 2|p| + d2 and divisor 2*d2 give round-half-away.
      out_carry.agents       <= ag4_ff;
      out_carry.status       <= st4_ff;
      out_carry.fixed_first  <= fxf4_ff;
      out_carry.fixed_second <= fxs4_ff;
      out_den <= {dsq4_ff, 1'b0};
      for (int i = 0; i < LANES; i++) begin
         out_num[i] <= {1'b0, mag[i], 1'b0} + NUM_W'(dsq4_ff);
         out_neg[i] <= pr4_ff[i][NPR_W-1];
      end
   end

endmodule

`default_nettype wire

FILE: sv/scr_div.sv
// Pipelined restoring divider, one quotient bit per stage, with sign applied at the end.
// Computes the rounded velocity projection of one lane. Uses scr_pkg.
`default_nettype none

module scr_div (
   input  logic                              clock,
   input  logic [scr_pkg::NUM_W-1:0]         num,
   input  logic [scr_pkg::DEN_W-1:0]         den,
   input  logic                              neg,
   output logic signed [scr_pkg::PROJ_W-1:0] proj
);
   import scr_pkg::*;

   // Per-stage registers: partial remainder, unused dividend bits, quotient so far, divisor and sign.
   logic [DEN_W-1:0] rem_ff  [QUO_W];
   logic [QUO_W-1:0] low_ff  [QUO_W];
   logic [QUO_W-1:0] quo_ff  [QUO_W];
   logic [DEN_W-1:0] den_ff  [QUO_W];
   logic             neg_ff  [QUO_W];

   // Stage inputs and trial subtraction.
   logic [DEN_W-1:0] rem_src [QUO_W];
   logic [QUO_W-1:0] low_src [QUO_W];
   logic [QUO_W-1:0] quo_src [QUO_W];
   logic [DEN_W-1:0] den_src [QUO_W];
   logic             neg_src [QUO_W];
   logic [DEN_W:0]   trial   [QUO_W];
   logic [DEN_W:0]   diff    [QUO_W];
   logic             ge      [QUO_W];

   // Each stage shifts in one dividend bit and decides one quotient bit.
   always_comb begin
      for (int s = 0; s < QUO_W; s++) begin
         if (s == 0) begin
            rem_src[s] = num[QUO_W +: DEN_W];
            low_src[s] = num[QUO_W-1:0];
            quo_src[s] = '0;
            den_src[s] = den;
            neg_src[s] = neg;
         end else begin
            rem_src[s] = rem_ff[s-1];
            low_src[s] = low_ff[s-1];
            quo_src[s] = quo_ff[s-1];
            den_src[s] = den_ff[s-1];
            neg_src[s] = neg_ff[s-1];
         end
         trial[s] = {rem_src[s], low_src[s][QUO_W-1]};
         diff[s]  = trial[s] - {1'b0, den_src[s]};
         ge[s]    = trial[s] >= {1'b0, den_src[s]};
      end
   end

   always_ff @(posedge clock) begin
      for (int s = 0; s < QUO_W; s++) begin
         rem_ff[s] <= ge[s] ? diff[s][DEN_W-1:0] : trial[s][DEN_W-1:0];
         low_ff[s] <= {low_src[s][QUO_W-2:0], 1'b0};
         quo_ff[s] <= {quo_src[s][QUO_W-2:0], ge[s]};
         den_ff[s] <= den_src[s];
         neg_ff[s] <= neg_src[s];
      end
   end

   // Signed projection from the final stage.
   assign proj = neg_ff[QUO_W-1] ? -$signed({1'b0, quo_ff[QUO_W-1]})
                                 : $signed({1'b0, quo_ff[QUO_W-1]});

endmodule

`default_nettype wire

FILE: sv/scr_back.sv
// Back half of the pipeline: corrected velocity, step scaling and new position,
// then selection against the pass-through values. Uses scr_pkg.
`default_nettype none

module scr_back (
   input  logic                                        clock,
   input  logic                                        reset,
   input  scr_pkg::carry_type                          in_carry,
   input  logic signed [scr_pkg::LANES-1:0][scr_pkg::PROJ_W-1:0] in_proj,
   input  logic [scr_pkg::COORD_W-1:0]                 time_step,
   output logic                                        out_valid,
   output logic [1:0]                                  out_status,
   output logic                                        out_fixed_first,
   output logic                                        out_fixed_second,
   output logic [scr_pkg::VEC_W-1:0]                   out_vel_first,
   output logic [scr_pkg::VEC_W-1:0]                   out_pos_first,
   output logic [scr_pkg::VEC_W-1:0]                   out_vel_second,
   output logic [scr_pkg::VEC_W-1:0]                   out_pos_second
);
   import scr_pkg::*;

   carry_type                  c1_ff, c2_ff;
   logic signed [COORD_W-1:0]  nv1_ff [LANES];
   logic signed [COORD_W-1:0]  nv1_in [LANES];
   logic signed [COORD_W-1:0]  nv2_ff [LANES];
   logic signed [TSP_W-1:0]    tp2_ff [LANES];
   logic signed [TSP_W-1:0]    tabs   [LANES];
   logic [RND_W-1:0]           rnd    [LANES];
   logic signed [SAT_W-1:0]    stp    [LANES];
   logic signed [COORD_W-1:0]  np_in  [LANES];
   logic [VEC_W-1:0]           prev_sel [AGENTS];
   logic [VEC_W-1:0]           vel_sel  [AGENTS];

   // Stage 1 logic: subtract the projection from the velocity.
   always_comb begin
      vel_sel[0] = in_carry.agents.vel_first;
      vel_sel[1] = in_carry.agents.vel_second;
      for (int a = 0; a < AGENTS; a++) begin
         for (int k = 0; k < AXES; k++) begin
            nv1_in[a*AXES+k] = sat16(SAT_W'(lane(vel_sel[a], k)) -
                                     SAT_W'($signed(in_proj[a*AXES+k])));
         end
      end
   end

   // Stage 3 logic: round the scaled velocity to Q8.8 and add the previous position.
   always_comb begin
      prev_sel[0] = c2_ff.agents.prev_first;
      prev_sel[1] = c2_ff.agents.prev_second;
      for (int a = 0; a < AGENTS; a++) begin
         for (int k = 0; k < AXES; k++) begin
            tabs[a*AXES+k] = tp2_ff[a*AXES+k][TSP_W-1] ? -tp2_ff[a*AXES+k]
                                                       : tp2_ff[a*AXES+k];
            rnd[a*AXES+k]  = RND_W'((tabs[a*AXES+k] + TSP_W'(128)) >>> 8);
            stp[a*AXES+k]  = tp2_ff[a*AXES+k][TSP_W-1] ? -$signed(SAT_W'(rnd[a*AXES+k]))
                                                       : $signed(SAT_W'(rnd[a*AXES+k]));
            np_in[a*AXES+k] = sat16(SAT_W'(lane(prev_sel[a], k)) + stp[a*AXES+k]);
         end
      end
   end

   // Output valid bit.
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid <= 1'b0;
      end else begin
         out_valid <= c2_ff.valid;
      end
   end

   // Data path registers and output selection; stage valid bits travel with their carry.
   always_ff @(posedge clock) begin
      if (reset) begin
         c1_ff.valid <= 1'b0;
         c2_ff.valid <= 1'b0;
      end else begin
         c1_ff.valid <= in_carry.valid;
         c2_ff.valid <= c1_ff.valid;
      end
      c1_ff.status       <= in_carry.status;
      c1_ff.fixed_first  <= in_carry.fixed_first;
      c1_ff.fixed_second <= in_carry.fixed_second;
      c1_ff.agents       <= in_carry.agents;
      c2_ff.status       <= c1_ff.status;
      c2_ff.fixed_first  <= c1_ff.fixed_first;
      c2_ff.fixed_second <= c1_ff.fixed_second;
      c2_ff.agents       <= c1_ff.agents;
      for (int i = 0; i < LANES; i++) begin
         nv1_ff[i] <= nv1_in[i];
         nv2_ff[i] <= nv1_ff[i];
         tp2_ff[i] <= TSP_W'(nv1_ff[i]) * $signed({1'b0, time_step});
      end
      out_status       <= c2_ff.status;
      out_fixed_first  <= c2_ff.fixed_first;
      out_fixed_second <= c2_ff.fixed_second;
      out_vel_first  <= c2_ff.fixed_first ? {nv2_ff[2], nv2_ff[1], nv2_ff[0]}
                                          : c2_ff.agents.vel_first;
      out_pos_first  <= c2_ff.fixed_first ? {np_in[2], np_in[1], np_in[0]}
                                          : c2_ff.agents.pos_first;
      out_vel_second <= c2_ff.fixed_second ? {nv2_ff[5], nv2_ff[4], nv2_ff[3]}
                                           : c2_ff.agents.vel_second;
      out_pos_second <= c2_ff.fixed_second ? {np_in[5], np_in[4], np_in[3]}
                                           : c2_ff.agents.pos_second;
   end

endmodule

`default_nettype wire

FILE: sv/sphere_collision_response_top.sv
// Top level of the sphere collision response block: register file, front pipeline,
// six lane dividers, carry delay line and back pipeline. Uses scr_pkg, scr_front,
// scr_div and scr_back.
//
// Usage:
//   Request channel: drive the req_ fields and raise start; a transaction is taken
//   at every clock edge where start is high and busy is low. busy stays low, so a
//   new agent pair can be issued on every cycle.
//   Response channel: rsp_valid is high for exactly one cycle with the result
//   fields; the receiver cannot stall, so results must be captured that cycle.
//   A transaction passes from the accepting edge to the result through
//   5 front stages (differences, products, sums, dot times difference, dividend),
//   17 divider stages (one quotient bit each) and 3 back stages. Throughput is one
//   pair per cycle; results come out in request order.
//   Register channel: csr_valid/csr_ready with csr_index and csr_data; csr_ready is
//   always high. Index 0 is time_step, index 1 is overlap_epsilon, other indexes are
//   ignored. Write registers only while no transaction is in flight.
//   Reset (synchronous, active high) clears all valid bits and restores time_step
//   to 1.0 and overlap_epsilon to 1/256; transactions in flight are dropped.
`default_nettype none

module sphere_collision_response_top (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               start,
   output logic                               busy,
   input  logic [scr_pkg::VEC_W-1:0]          req_pos_first,
   input  logic [scr_pkg::VEC_W-1:0]          req_pos_second,
   input  logic [scr_pkg::VEC_W-1:0]          req_prev_first,
   input  logic [scr_pkg::VEC_W-1:0]          req_prev_second,
   input  logic [scr_pkg::VEC_W-1:0]          req_vel_first,
   input  logic [scr_pkg::VEC_W-1:0]          req_vel_second,
   input  logic [scr_pkg::COORD_W-1:0]        req_mass_first,
   input  logic [scr_pkg::COORD_W-1:0]        req_mass_second,
   input  logic [scr_pkg::COORD_W-1:0]        req_radius_first,
   input  logic [scr_pkg::COORD_W-1:0]        req_radius_second,
   output logic                               rsp_valid,
   output logic [1:0]                         rsp_contact_status,
   output logic                               rsp_fixed_first,
   output logic                               rsp_fixed_second,
   output logic [scr_pkg::VEC_W-1:0]          rsp_new_vel_first,
   output logic [scr_pkg::VEC_W-1:0]          rsp_new_pos_first,
   output logic [scr_pkg::VEC_W-1:0]          rsp_new_vel_second,
   output logic [scr_pkg::VEC_W-1:0]          rsp_new_pos_second,
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [scr_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [scr_pkg::COORD_W-1:0]        csr_data
);
   import scr_pkg::*;

   logic [COORD_W-1:0]              time_step_ff;
   logic [COORD_W-1:0]              overlap_eps_ff;
   agents_type                      req_agents;
   carry_type                       front_carry;
   logic [LANES-1:0][NUM_W-1:0]     front_num;
   logic [DEN_W-1:0]                front_den;
   logic [LANES-1:0]                front_neg;
   logic signed [LANES-1:0][PROJ_W-1:0] proj;
   carry_type                       dly_ff [QUO_W];

   // The pipeline never refuses a transaction.
   assign busy      = 1'b0;
   assign csr_ready = 1'b1;

   // Register file.
   always_ff @(posedge clock) begin
      if (reset) begin
         time_step_ff   <= TIME_STEP_RESET;
         overlap_eps_ff <= OVERLAP_RESET;
      end else if (csr_valid && csr_ready) begin
         if (csr_index == CSR_TIME_STEP) begin
            time_step_ff <= csr_data;
         end else if (csr_index == CSR_OVERLAP_EPS) begin
            overlap_eps_ff <= csr_data;
         end
      end
   end

   assign req_agents.pos_first   = req_pos_first;
   assign req_agents.pos_second  = req_pos_second;
   assign req_agents.prev_first  = req_prev_first;
   assign req_agents.prev_second = req_prev_second;
   assign req_agents.vel_first   = req_vel_first;
   assign req_agents.vel_second  = req_vel_second;

   // Geometry, decision and dividends.
   scr_front u_front (
      .clock            (clock),
      .reset            (reset),
      .in_valid         (start && !busy),
      .in_agents        (req_agents),
      .in_mass_first    (req_mass_first),
      .in_mass_second   (req_mass_second),
      .in_radius_first  (req_radius_first),
      .in_radius_second (req_radius_second),
      .overlap_eps      (overlap_eps_ff),
      .out_carry        (front_carry),
      .out_num          (front_num),
      .out_den          (front_den),
      .out_neg          (front_neg)
   );

   // One divider per agent and axis.
   for (genvar i = 0; i < LANES; i++) begin : g_lane
      scr_div u_div (
         .clock (clock),
         .num   (front_num[i]),
         .den   (front_den),
         .neg   (front_neg[i]),
         .proj  (proj[i])
      );
   end

   // Carry delay line matching the divider depth.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int s = 0; s < QUO_W; s++) begin
            dly_ff[s].valid <= 1'b0;
         end
      end else begin
         dly_ff[0] <= front_carry;
         for (int s = 1; s < QUO_W; s++) begin
            dly_ff[s] <= dly_ff[s-1];
         end
      end
   end

   // Velocity correction, position update and output registers.
   scr_back u_back (
      .clock            (clock),
      .reset            (reset),
      .in_carry         (dly_ff[QUO_W-1]),
      .in_proj          (proj),
      .time_step        (time_step_ff),
      .out_valid        (rsp_valid),
      .out_status       (rsp_contact_status),
      .out_fixed_first  (rsp_fixed_first),
      .out_fixed_second (rsp_fixed_second),
      .out_vel_first    (rsp_new_vel_first),
      .out_pos_first    (rsp_new_pos_first),
      .out_vel_second   (rsp_new_vel_second),
      .out_pos_second   (rsp_new_pos_second)
   );

endmodule

`default_nettype wire

FILE: sv/scr_checker.sv
// Port-level checks for the sphere collision response block, bound to its top level.
// Uses scr_pkg for the latency and status codes.
`default_nettype none

module scr_checker (
   input logic       clock,
   input logic       reset,
   input logic       start,
   input logic       busy,
   input logic       rsp_valid,
   input logic [1:0] rsp_contact_status,
   input logic       rsp_fixed_first,
   input logic       rsp_fixed_second
);
   import scr_pkg::*;

   // Every accepted transaction produces a response after the fixed latency.
   a_resp_follows: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |-> ##LATENCY rsp_valid)
      else $error("accepted transaction produced no response");

   // No response appears without a transaction accepted that many cycles earlier.
   a_no_spurious: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(start && !busy && !reset, LATENCY))
      else $error("response without a matching transaction");

   // A corrected agent only occurs for a collision.
   a_fixed_needs_hit: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_fixed_first || rsp_fixed_second)) |->
      (rsp_contact_status == STATUS_HIT))
      else $error("agent corrected without a collision");

endmodule

bind sphere_collision_response_top scr_checker u_scr_checker (
   .clock              (clock),
   .reset              (reset),
   .start              (start),
   .busy               (busy),
   .rsp_valid          (rsp_valid),
   .rsp_contact_status (rsp_contact_status),
   .rsp_fixed_first    (rsp_fixed_first),
   .rsp_fixed_second   (rsp_fixed_second)
);

`default_nettype wire
